/* rtl/core/frtw_pkg.sv */
`timescale 1ns / 1ps
package frtw_pkg;

	localparam int FIELD_W = 40;
	localparam int RATIO_W = 16;
	localparam int WT_W    = 18;
	localparam int CNT_W   = 3;
	localparam int IDX_W   = 3;
	localparam int ACC_W   = 20;

	localparam logic [IDX_W-1:0] REG_RATIO_NUM    = 3'd0;
	localparam logic [IDX_W-1:0] REG_RATIO_DEN    = 3'd1;
	localparam logic [IDX_W-1:0] REG_MODE         = 3'd2;
	localparam logic [IDX_W-1:0] REG_KERNEL_SHARP = 3'd3;
	localparam logic [IDX_W-1:0] REG_FLOOR_REPEAT = 3'd4;
	localparam logic [IDX_W-1:0] REG_SWAP_WEIGHTS = 3'd5;

	localparam logic [1:0] MODE_DROP   = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_CUBIC  = 2'd2;

	localparam logic [CNT_W-1:0] TAPS_DROP   = 3'd1;
	localparam logic [CNT_W-1:0] TAPS_LINEAR = 3'd2;
	localparam logic [CNT_W-1:0] TAPS_CUBIC  = 3'd4;

	localparam logic signed [ACC_W-1:0] ONE_Q16 = 20'sd65536;

	typedef struct packed {
		logic [RATIO_W-1:0] num;
		logic [RATIO_W-1:0] den;
		logic [1:0]         mode;
		logic               sharp;
		logic               floor_rep;
		logic               swap;
	} cfg_t;

endpackage

/* rtl/core/frtw_ifs.sv */
`timescale 1ns / 1ps
interface frtw_in_if;
	logic               valid;
	logic               ready;
	logic signed [39:0] field_index;
	modport source(output valid, output field_index, input ready);
	modport sink(input valid, input field_index, output ready);
endinterface

interface frtw_out_if;
	logic               valid;
	logic               ready;
	logic signed [39:0] first_field;
	logic [2:0]         tap_count;
	logic [15:0]        phase;
	logic signed [17:0] weight_a;
	logic signed [17:0] weight_b;
	logic signed [17:0] weight_c;
	logic signed [17:0] weight_d;
	modport source(output valid, output first_field, output tap_count, output phase,
		output weight_a, output weight_b, output weight_c, output weight_d, input ready);
	modport sink(input valid, input first_field, input tap_count, input phase,
		input weight_a, input weight_b, input weight_c, input weight_d, output ready);
endinterface

interface frtw_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* rtl/core/frtw_front.sv */
`timescale 1ns / 1ps
module frtw_front #(
	parameter int PHASE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  frtw_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [frtw_pkg::FIELD_W-1:0] in_index,
	output logic                              o_valid,
	input  logic                              o_ready,
	output logic [frtw_pkg::FIELD_W-1:0]      o_whole,
	output logic [PHASE_BITS-1:0]             o_phase,
	output logic                              o_later
);
	import frtw_pkg::*;

	localparam int UW = FIELD_W + RATIO_W - 1;
	localparam int PB = PHASE_BITS;

	logic signed [UW:0] prod;
	logic               adv;

	// integer quotient stages, one bit each
	logic             iv_q [0:UW];
	logic             ng_q [0:UW];
	logic [UW-1:0]    dv_q [0:UW];
	logic [RATIO_W-1:0] rv_q [0:UW];
	logic [FIELD_W-1:0] qv_q [0:UW];
	logic [UW-1:0]    dv_n [0:UW-1];
	logic [RATIO_W-1:0] rv_n [0:UW-1];
	logic [FIELD_W-1:0] qv_n [0:UW-1];

	// phase stages
	logic               pv_q [0:PB];
	logic [RATIO_W-1:0] pr_q [0:PB];
	logic [PB-1:0]      pp_q [0:PB];
	logic [FIELD_W-1:0] pw_q [0:PB];
	logic               pl_q [0:PB];
	logic [RATIO_W-1:0] pr_n [0:PB-1];
	logic [PB-1:0]      pp_n [0:PB-1];

	logic [RATIO_W-1:0] rem_c;
	logic [FIELD_W-1:0] whole_c;
	logic               later_c;

	assign prod     = in_index * $signed({1'b0, cfg.num});
	assign adv      = !pv_q[PB] || o_ready;
	assign in_ready = adv;

	always_comb begin
		logic [RATIO_W:0] t;
		logic             ge;
		for (int k = 0; k < UW; k++) begin
			t  = {rv_q[k], dv_q[k][UW-1]};
			ge = t >= {1'b0, cfg.den};
			rv_n[k] = ge ? RATIO_W'(t - {1'b0, cfg.den}) : t[RATIO_W-1:0];
			dv_n[k] = {dv_q[k][UW-2:0], 1'b0};
			qv_n[k] = {qv_q[k][FIELD_W-2:0], ge};
		end
	end

	// negative dividends were divided as ~n, map back to floor quotient and remainder
	always_comb begin
		rem_c   = ng_q[UW] ? RATIO_W'(cfg.den - RATIO_W'(1) - rv_q[UW]) : rv_q[UW];
		whole_c = ng_q[UW] ? ~qv_q[UW] : qv_q[UW];
		later_c = !cfg.floor_rep && ({rem_c, 1'b0} > {1'b0, cfg.den});
	end

	always_comb begin
		logic [RATIO_W:0] t;
		logic             ge;
		for (int k = 0; k < PB; k++) begin
			t  = {pr_q[k], 1'b0};
			ge = t >= {1'b0, cfg.den};
			pr_n[k] = ge ? RATIO_W'(t - {1'b0, cfg.den}) : t[RATIO_W-1:0];
			pp_n[k] = {pp_q[k][PB-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= UW; k++) iv_q[k] <= 1'b0;
			for (int k = 0; k <= PB; k++) pv_q[k] <= 1'b0;
		end else if (adv) begin
			iv_q[0] <= in_valid;
			for (int k = 0; k < UW; k++) iv_q[k+1] <= iv_q[k];
			pv_q[0] <= iv_q[UW];
			for (int k = 0; k < PB; k++) pv_q[k+1] <= pv_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ng_q[0] <= prod[UW];
			dv_q[0] <= prod[UW] ? ~prod[UW-1:0] : prod[UW-1:0];
			rv_q[0] <= '0;
			qv_q[0] <= '0;
			for (int k = 0; k < UW; k++) begin
				ng_q[k+1] <= ng_q[k];
				dv_q[k+1] <= dv_n[k];
				rv_q[k+1] <= rv_n[k];
				qv_q[k+1] <= qv_n[k];
			end
			pr_q[0] <= rem_c;
			pp_q[0] <= '0;
			pw_q[0] <= whole_c;
			pl_q[0] <= later_c;
			for (int k = 0; k < PB; k++) begin
				pr_q[k+1] <= pr_n[k];
				pp_q[k+1] <= pp_n[k];
				pw_q[k+1] <= pw_q[k];
				pl_q[k+1] <= pl_q[k];
			end
		end
	end

	assign o_valid = pv_q[PB];
	assign o_whole = pw_q[PB];
	assign o_phase = pp_q[PB];
	assign o_later = pl_q[PB];

endmodule

/* rtl/core/frtw_queue.sv */
`timescale 1ns / 1ps
module frtw_queue #(
	parameter int W = 57
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         i_valid,
	output logic         i_ready,
	input  logic [W-1:0] i_data,
	output logic         o_valid,
	input  logic         o_ready,
	output logic [W-1:0] o_data
);
	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	logic [W-1:0] mem [0:DEPTH-1];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign i_ready = cnt_q != (AW+1)'(DEPTH);
	assign o_valid = cnt_q != '0;
	assign o_data  = mem[rp_q];
	assign push    = i_valid && i_ready;
	assign pop     = o_valid && o_ready;

	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= i_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + AW'(1);
			if (pop) rp_q <= rp_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + (AW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

endmodule

/* rtl/core/frtw_back.sv */
`timescale 1ns / 1ps
module frtw_back #(
	parameter int PHASE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  frtw_pkg::cfg_t               cfg,
	input  logic                         i_valid,
	output logic                         i_ready,
	input  logic [frtw_pkg::FIELD_W-1:0] i_whole,
	input  logic [PHASE_BITS-1:0]        i_phase,
	input  logic                         i_later,
	output logic                         o_valid,
	input  logic                         o_ready,
	output logic [frtw_pkg::FIELD_W-1:0] o_first,
	output logic [frtw_pkg::CNT_W-1:0]   o_count,
	output logic [15:0]                  o_phase,
	output logic [frtw_pkg::WT_W-1:0]    o_wa,
	output logic [frtw_pkg::WT_W-1:0]    o_wb,
	output logic [frtw_pkg::WT_W-1:0]    o_wc,
	output logic [frtw_pkg::WT_W-1:0]    o_wd
);
	import frtw_pkg::*;

	localparam int PB = PHASE_BITS;
	localparam int MW = 2 * PB + 4;
	localparam int LO = MW / 2;
	localparam int HI = MW - LO;
	localparam int PW = MW + PB + 1;
	localparam int SH = 3 * PB - 14;
	localparam int RW = PW - SH;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_q;

	logic [PB-1:0]      p_s1, p_s2, p_s3, p_s4, p_s5;
	logic [PB:0]        q_s1, q_s2, q_s3;
	logic [FIELD_W-1:0] wh_s1, wh_s2, wh_s3, wh_s4, wh_s5;
	logic               lt_s1, lt_s2, lt_s3, lt_s4, lt_s5;
	logic [2*PB:0]      pq_s2;
	logic [2*PB-1:0]    pp_s2;
	logic [MW-1:0]      m0_s3, m3_s3, e_s3;
	logic [LO+PB:0]     l0_s4, l3_s4, l2_s4;
	logic [HI+PB:0]     h0_s4, h3_s4, h2_s4;
	logic [RW-1:0]      r0_s5, r3_s5, r2_s5;

	logic [MW-1:0]      pq_x, pp_x, p_x;
	logic [PW-1:0]      f0, f3, f2;
	logic [16:0]        t16;
	logic [15:0]        ph16;

	assign adv     = !vld_q || o_ready;
	assign i_ready = adv;

	always_comb begin
		pq_x = MW'(pq_s2);
		pp_x = MW'(pp_s2);
		p_x  = MW'(p_s2);
	end

	always_comb begin
		logic [PW-1:0] half;
		half = PW'(1) << (SH - 1);
		f0 = (PW'(h0_s4) << LO) + PW'(l0_s4) + half;
		f3 = (PW'(h3_s4) << LO) + PW'(l3_s4) + half;
		f2 = (PW'(h2_s4) << LO) + PW'(l2_s4) + half;
	end

	generate
		if (PB > 16) begin : g_wide
			logic [PB:0] tr;
			assign tr   = {1'b0, p_s5} + ((PB+1)'(1) << (PB - 17));
			assign t16  = 17'(tr >> (PB - 16));
			assign ph16 = p_s5[PB-1 -: 16];
		end else if (PB == 16) begin : g_exact
			assign t16  = {1'b0, p_s5};
			assign ph16 = p_s5;
		end else begin : g_narrow
			assign t16  = {1'b0, p_s5, (16-PB)'(0)};
			assign ph16 = {p_s5, (16-PB)'(0)};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_s1 <= i_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_q  <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [ACC_W-1:0] w0, w1, w2, w3, c0, c2, c3, tl;
		logic [FIELD_W-1:0]      first;
		logic [CNT_W-1:0]        cnt;
		if (adv) begin
			p_s1  <= i_phase;
			q_s1  <= {1'b1, PB'(0)} - {1'b0, i_phase};
			wh_s1 <= i_whole;
			lt_s1 <= i_later;

			pq_s2 <= p_s1 * q_s1;
			pp_s2 <= p_s1 * p_s1;
			p_s2  <= p_s1;
			q_s2  <= q_s1;
			wh_s2 <= wh_s1;
			lt_s2 <= lt_s1;

			// A*PQ, A*PP and the cubic bracket e; A is 2 or 3
			m0_s3 <= (pq_x << 1) + (cfg.sharp ? pq_x : MW'(0));
			m3_s3 <= (pp_x << 1) + (cfg.sharp ? pp_x : MW'(0));
			if (cfg.sharp) begin
				e_s3 <= (MW'(3) << (2*PB)) + (((p_x << 2) + (p_x << 1)) << PB)
					- ((pp_x << 2) + pp_x);
			end else begin
				e_s3 <= (MW'(2) << (2*PB)) + ((p_x << 3) << PB)
					- ((pp_x << 2) + (pp_x << 1));
			end
			p_s3  <= p_s2;
			q_s3  <= q_s2;
			wh_s3 <= wh_s2;
			lt_s3 <= lt_s2;

			l0_s4 <= m0_s3[LO-1:0] * q_s3;
			h0_s4 <= m0_s3[MW-1:LO] * q_s3;
			l3_s4 <= m3_s3[LO-1:0] * q_s3;
			h3_s4 <= m3_s3[MW-1:LO] * q_s3;
			l2_s4 <= e_s3[LO-1:0] * {1'b0, p_s3};
			h2_s4 <= e_s3[MW-1:LO] * {1'b0, p_s3};
			p_s4  <= p_s3;
			wh_s4 <= wh_s3;
			lt_s4 <= lt_s3;

			r0_s5 <= f0[PW-1:SH];
			r3_s5 <= f3[PW-1:SH];
			r2_s5 <= f2[PW-1:SH];
			p_s5  <= p_s4;
			wh_s5 <= wh_s4;
			lt_s5 <= lt_s4;

			c0 = $signed(ACC_W'(r0_s5));
			c2 = $signed(ACC_W'(r2_s5));
			c3 = $signed(ACC_W'(r3_s5));
			tl = $signed(ACC_W'(t16));
			w0 = '0;
			w1 = '0;
			w2 = '0;
			w3 = '0;
			case (cfg.mode)
				MODE_DROP: begin
					first = wh_s5 + FIELD_W'(lt_s5);
					cnt   = TAPS_DROP;
					w0    = ONE_Q16;
				end
				MODE_CUBIC: begin
					first = wh_s5 - FIELD_W'(1);
					cnt   = TAPS_CUBIC;
					if (cfg.swap) begin
						w0 = -c3;
						w1 = c2;
						w2 = ONE_Q16 + c0 + c3 - c2;
						w3 = -c0;
					end else begin
						w0 = -c0;
						w1 = ONE_Q16 + c0 + c3 - c2;
						w2 = c2;
						w3 = -c3;
					end
				end
				default: begin
					first = wh_s5;
					cnt   = TAPS_LINEAR;
					if (cfg.swap) begin
						w0 = tl;
						w1 = ONE_Q16 - tl;
					end else begin
						w0 = ONE_Q16 - tl;
						w1 = tl;
					end
				end
			endcase
			o_first <= first;
			o_count <= cnt;
			o_phase <= ph16;
			o_wa    <= w0[WT_W-1:0];
			o_wb    <= w1[WT_W-1:0];
			o_wc    <= w2[WT_W-1:0];
			o_wd    <= w3[WT_W-1:0];
		end
	end

	assign o_valid = vld_q;

endmodule

/* rtl/core/field_rate_tap_weight_generator.sv */
`timescale 1ns / 1ps
// channel   dir  payload                                         request moves
// in_ch     in   field_index                                     one destination field
// out_ch    out  first_field tap_count phase weight_a..weight_d  one tap set
// cfg_ch    in   index data                                      one register write
//
// One request per cycle sustained while out_ch is ready. A request passes 55 one-bit quotient
// stages behind the input register, one remainder fix, PHASE_BITS phase stages, the queue,
// then six weight stages.
// A four-entry queue sits between the divider and the weight pipeline; each side stalls
// on its own. Reset clears valid bits and restores register defaults; cfg_ch never stalls.
module field_rate_tap_weight_generator #(
	parameter int PHASE_BITS = 16
) (
	input logic         clk,
	input logic         arst_n,
	frtw_in_if.sink     in_ch,
	frtw_out_if.source  out_ch,
	frtw_cfg_if.sink    cfg_ch
);
	import frtw_pkg::*;

	localparam int QW = FIELD_W + PHASE_BITS + 1;

	logic [RATIO_W-1:0] num_q, den_q;
	logic [1:0]         mode_q;
	logic               sharp_q, floor_q, swap_q;
	cfg_t               cfg;

	logic               f_valid, f_ready, f_later, b_valid, b_ready;
	logic [FIELD_W-1:0] f_whole;
	logic [PHASE_BITS-1:0] f_phase;
	logic [QW-1:0]      q_out;
	logic [FIELD_W-1:0] o_first;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q   <= RATIO_W'(1);
			den_q   <= RATIO_W'(1);
			mode_q  <= MODE_LINEAR;
			sharp_q <= 1'b0;
			floor_q <= 1'b0;
			swap_q  <= 1'b0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_RATIO_NUM:    num_q   <= cfg_ch.data;
				REG_RATIO_DEN:    den_q   <= cfg_ch.data;
				REG_MODE:         mode_q  <= cfg_ch.data[1:0];
				REG_KERNEL_SHARP: sharp_q <= cfg_ch.data[0];
				REG_FLOOR_REPEAT: floor_q <= cfg_ch.data[0];
				REG_SWAP_WEIGHTS: swap_q  <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.num       = num_q;
		cfg.den       = (den_q == '0) ? RATIO_W'(1) : den_q;
		cfg.mode      = mode_q;
		cfg.sharp     = sharp_q;
		cfg.floor_rep = floor_q;
		cfg.swap      = swap_q;
	end

	frtw_front #(.PHASE_BITS(PHASE_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_index (in_ch.field_index),
		.o_valid  (f_valid),
		.o_ready  (f_ready),
		.o_whole  (f_whole),
		.o_phase  (f_phase),
		.o_later  (f_later)
	);

	frtw_queue #(.W(QW)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.i_valid (f_valid),
		.i_ready (f_ready),
		.i_data  ({f_whole, f_phase, f_later}),
		.o_valid (b_valid),
		.o_ready (b_ready),
		.o_data  (q_out)
	);

	frtw_back #(.PHASE_BITS(PHASE_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.i_valid (b_valid),
		.i_ready (b_ready),
		.i_whole (q_out[QW-1 -: FIELD_W]),
		.i_phase (q_out[PHASE_BITS:1]),
		.i_later (q_out[0]),
		.o_valid (out_ch.valid),
		.o_ready (out_ch.ready),
		.o_first (o_first),
		.o_count (out_ch.tap_count),
		.o_phase (out_ch.phase),
		.o_wa    (out_ch.weight_a),
		.o_wb    (out_ch.weight_b),
		.o_wc    (out_ch.weight_c),
		.o_wd    (out_ch.weight_d)
	);

	assign out_ch.first_field = $signed(o_first);

	a_taps_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.tap_count == TAPS_DROP || out_ch.tap_count == TAPS_LINEAR
			|| out_ch.tap_count == TAPS_CUBIC))
		else $error("illegal tap count");

	a_linear_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.tap_count == TAPS_LINEAR) |->
		(ACC_W'(out_ch.weight_a) + ACC_W'(out_ch.weight_b) == ONE_Q16))
		else $error("linear weights do not sum to one");

	a_cubic_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.tap_count == TAPS_CUBIC) |->
		(ACC_W'(out_ch.weight_a) + ACC_W'(out_ch.weight_b) + ACC_W'(out_ch.weight_c)
			+ ACC_W'(out_ch.weight_d) == ONE_Q16))
		else $error("cubic weights do not sum to one");

endmodule

/* tb/field_rate_tap_weight_generator_test.sv */
`timescale 1ns / 1ps
module field_rate_tap_weight_generator_test;
	import frtw_pkg::*;

	typedef struct {
		logic [39:0] first_field;
		logic [2:0]  tap_count;
		logic [15:0] phase;
		logic [17:0] w [4];
	} taps_t;

	class tap_scoreboard;
		taps_t       expected_taps [$];
		int          mismatches;
		int          checked;
		logic [15:0] num, den;
		logic [1:0]  mode;
		logic        sharp, floor_rep, swap;

		function new();
			num = 1; den = 1; mode = MODE_LINEAR; sharp = 0; floor_rep = 0; swap = 0;
			mismatches = 0; checked = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				REG_RATIO_NUM: num = data;
				REG_RATIO_DEN: den = data;
				REG_MODE: mode = data[1:0];
				REG_KERNEL_SHARP: sharp = data[0];
				REG_FLOOR_REPEAT: floor_rep = data[0];
				REG_SWAP_WEIGHTS: swap = data[0];
				default: ;
			endcase
		endfunction

		// note an accepted request and predict its tap set
		function void note_request(logic signed [39:0] idx);
			longint j, n, d, whole, rem, first, t;
			longint w [4];
			bit [127:0] a, p, q, s, e, r0, r2, r3;
			taps_t x;
			int cnt;
			d = (den == 0) ? 1 : longint'(den);
			j = longint'(idx);
			n = j * longint'(num);
			whole = n / d;
			if ((n % d) != 0 && n < 0)
				whole -= 1;
			rem = n - whole * d;
			p = 128'((rem << 16) / d);
			w = '{0, 0, 0, 0};
			if (mode == MODE_DROP) begin
				cnt = 1;
				first = whole + ((!floor_rep && 2 * rem > d) ? 1 : 0);
				w[0] = 65536;
			end else if (mode == MODE_CUBIC) begin
				a = sharp ? 3 : 2;
				s = 65536;
				q = s - p;
				e = a * s * s + (12 - 2 * a) * p * s - (8 - a) * p * p;
				r0 = (a * p * q * q + (128'd1 << 33)) >> 34;
				r3 = (a * p * p * q + (128'd1 << 33)) >> 34;
				r2 = (e * p + (128'd1 << 33)) >> 34;
				cnt = 4;
				first = whole - 1;
				w[0] = -longint'(r0);
				w[2] = longint'(r2);
				w[3] = -longint'(r3);
				w[1] = 65536 + longint'(r0) + longint'(r3) - longint'(r2);
			end else begin
				cnt = 2;
				first = whole;
				w[1] = longint'(p);
				w[0] = 65536 - longint'(p);
			end
			if (swap) begin
				for (int i = 0; i < cnt / 2; i++) begin
					t = w[i];
					w[i] = w[cnt - 1 - i];
					w[cnt - 1 - i] = t;
				end
			end
			x.first_field = first[39:0];
			x.tap_count = cnt[2:0];
			x.phase = p[15:0];
			for (int i = 0; i < 4; i++)
				x.w[i] = w[i][17:0];
			expected_taps.push_back(x);
		endfunction

		function void check_result(taps_t got);
			taps_t x;
			bit bad;
			if (expected_taps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected tap set, first_field %0d", $signed(got.first_field));
				return;
			end
			x = expected_taps.pop_front();
			checked++;
			bad = (x.first_field !== got.first_field) || (x.tap_count !== got.tap_count)
				|| (x.phase !== got.phase);
			for (int i = 0; i < 4; i++)
				if (x.w[i] !== got.w[i])
					bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp ff=%0d n=%0d ph=%0d w=%0d %0d %0d %0d",
						$signed(x.first_field), x.tap_count, x.phase, $signed(x.w[0]),
						$signed(x.w[1]), $signed(x.w[2]), $signed(x.w[3]));
					$display("          got ff=%0d n=%0d ph=%0d w=%0d %0d %0d %0d",
						$signed(got.first_field), got.tap_count, got.phase,
						$signed(got.w[0]), $signed(got.w[1]), $signed(got.w[2]),
						$signed(got.w[3]));
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	frtw_in_if  in_ch();
	frtw_out_if out_ch();
	frtw_cfg_if cfg_ch();

	field_rate_tap_weight_generator dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	tap_scoreboard sb = new();
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int idle_cycles = 0;
	int requests = 0;
	int reg_writes = 0;
	localparam int WATCHDOG = 5000;
	localparam int NPHASES = 15;

	always begin
		clk = 1; #2;
		clk = 0; #2;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.field_index = '0;
		out_ch.ready = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
	end

	always @(negedge clk)
		if (arst_n)
			out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);

	always @(posedge clk) begin
		taps_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.first_field = out_ch.first_field;
			got.tap_count = out_ch.tap_count;
			got.phase = out_ch.phase;
			got.w[0] = out_ch.weight_a;
			got.w[1] = out_ch.weight_b;
			got.w[2] = out_ch.weight_c;
			got.w[3] = out_ch.weight_d;
			sb.check_result(got);
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 0;
	endtask

	task automatic send_field(logic signed [39:0] idx);
		@(negedge clk);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.field_index <= idx;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(idx);
		requests++;
	endtask

	function automatic logic [39:0] random_field();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return r[39:0];
			1: return 40'($signed($urandom_range(0, 4000)) - 2000);
			2: return 40'h7f_ffff_ffff - 40'($urandom_range(0, 300));
			default: return 40'h80_0000_0000 + 40'($urandom_range(0, 300));
		endcase
	endfunction

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 0;
		while (sb.expected_taps.size() != 0)
			@(posedge clk);
		repeat (110) @(posedge clk);
	endtask

	task automatic load_config(int num, int den, int mode, int sharp, int floor_rep,
		int swap);
		write_reg(REG_RATIO_NUM, 16'(num));
		write_reg(REG_RATIO_DEN, 16'(den));
		write_reg(REG_MODE, 16'(mode));
		write_reg(REG_KERNEL_SHARP, 16'(sharp));
		write_reg(REG_FLOOR_REPEAT, 16'(floor_rep));
		write_reg(REG_SWAP_WEIGHTS, 16'(swap));
	endtask

	initial begin
		int prof;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		for (int ph = 0; ph < NPHASES; ph++) begin
			prof = ph * 3 / NPHASES;
			in_idle_pct = (prof == 0) ? 37 : (prof == 1) ? 79 : 0;
			out_idle_pct = (prof == 0) ? 79 : (prof == 1) ? 37 : 0;
			case (ph)
				0: ; // defaults after reset
				1: load_config(3, 2, MODE_DROP, 0, 0, 0);     // half-way repeats earlier
				2: load_config(3, 2, MODE_DROP, 1, 1, 1);
				3: load_config(65535, 1, MODE_CUBIC, 1, 0, 1);
				4: load_config(1, 65535, MODE_CUBIC, 0, 1, 0);
				5: begin
					load_config(0, 0, MODE_LINEAR, 0, 0, 1);
					write_reg(3'd6, 16'hffff); // ignored indexes
					write_reg(3'd7, 16'h0000);
				end
				6: load_config(65535, 65534, 3, 1, 0, 0);    // unused mode acts as linear
				default: load_config($urandom_range(0, 65535), $urandom_range(1, 65535),
					$urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 1));
			endcase
			if (ph < 7) begin
				send_field(40'sd1);
				send_field(40'h7f_ffff_ffff);
				send_field(40'h80_0000_0000);
			end
			for (int k = 0; k < 120; k++)
				send_field(random_field());
			drain();
		end
		$display("covered %0d field requests over %0d register settings, %0d writes",
			requests, NPHASES, reg_writes);
		$display("%0d tap sets checked, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_taps.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

/* files.f */
rtl/core/frtw_pkg.sv
rtl/core/frtw_ifs.sv
rtl/core/frtw_front.sv
rtl/core/frtw_queue.sv
rtl/core/frtw_back.sv
rtl/core/field_rate_tap_weight_generator.sv
tb/field_rate_tap_weight_generator_test.sv
